FILE: sv/uds_pkg.sv
package uds_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NUM_DIGITS  = 10;

  // Reciprocal of ten scaled by 2^35, exact for every 31-bit dividend.
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [2:0] pc_t;

  localparam pc_t STEP_WAIT   = 3'd0;
  localparam pc_t STEP_BRANCH = 3'd1;
  localparam pc_t STEP_DIV    = 3'd2;
  localparam pc_t STEP_PUSH   = 3'd3;
  localparam pc_t STEP_OVF    = 3'd4;
  localparam pc_t STEP_POP    = 3'd5;
  localparam pc_t STEP_UNMARK = 3'd6;
  localparam pc_t STEP_EMIT   = 3'd7;

  typedef enum logic [2:0] {
    ACT_ACCEPT,
    ACT_NONE,
    ACT_DIV,
    ACT_PUSH,
    ACT_OVF,
    ACT_POP,
    ACT_UNMARK,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_POP,
    C_V_ZERO,
    C_NOT_FULL,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Each step jumps to its target when its condition holds, else falls through.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    w = '{act: ACT_NONE, cond: C_ALWAYS, target: STEP_WAIT};
    unique case (pc)
      STEP_WAIT:   w = '{act: ACT_ACCEPT, cond: C_NO_INPUT, target: STEP_WAIT};
      STEP_BRANCH: w = '{act: ACT_NONE,   cond: C_IS_POP,   target: STEP_POP};
      STEP_DIV:    w = '{act: ACT_DIV,    cond: C_V_ZERO,   target: STEP_EMIT};
      STEP_PUSH:   w = '{act: ACT_PUSH,   cond: C_NOT_FULL, target: STEP_DIV};
      STEP_OVF:    w = '{act: ACT_OVF,    cond: C_ALWAYS,   target: STEP_EMIT};
      STEP_POP:    w = '{act: ACT_POP,    cond: C_ALWAYS,   target: STEP_UNMARK};
      STEP_UNMARK: w = '{act: ACT_UNMARK, cond: C_ALWAYS,   target: STEP_EMIT};
      STEP_EMIT:   w = '{act: ACT_EMIT,   cond: C_OUT_BUSY, target: STEP_EMIT};
      default:     w = '{act: ACT_NONE,   cond: C_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/unique_digit_stack.sv
// A new input beat is taken only in the wait step, after the result of the last beat
// has been placed on the output. A pop runs the branch, pop, unmark and emit steps; a
// push runs the branch step, then the shared divide-by-ten unit and two microcode steps
// (divide, push) per digit, then the emit step, which holds while the output is stalled.
// Reset clears the step counter, the entry count, the digit presence flags and the
// output valid; the digit store itself is left as it was.
module unique_digit_stack (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic signed [31:0] value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [3:0]        popped_digit
);
  import uds_pkg::*;

  pc_t                     pc;
  pc_t                     pc_next;
  uword_t                  uw;
  logic                    cond_true;
  logic                    in_acc;
  logic                    out_busy;
  logic                    op_r;
  logic [30:0]             v;
  logic [27:0]             q;
  logic [62:0]             mul;
  logic [27:0]             q_calc;
  logic [30:0]             q_ext;
  logic [30:0]             rem;
  logic [3:0]              d;
  logic [1:0]              st_r;
  logic [3:0]              dig_r;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    full;
  logic                    dup;
  logic [NUM_DIGITS-1:0]   present;
  logic [3:0]              store [STACK_DEPTH];

  always_comb begin
    mul    = 63'(v) * 63'(RECIP_TEN);
    q_calc = mul[RECIP_SHIFT +: 28];
    q_ext  = 31'(q);
    rem    = v - ((q_ext << 3) + (q_ext << 1));
    d      = rem[3:0];
    full   = count >= CNT_W'(STACK_DEPTH);
    dup    = present[d];
    cnt_m1 = count - CNT_W'(1);
  end

  always_comb begin
    uw       = ucode_rom(pc);
    in_ready = (uw.act == ACT_ACCEPT);
    in_acc   = in_valid && in_ready;
    out_busy = out_valid && !out_ready;
  end

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_INPUT: cond_true = !in_valid;
      C_IS_POP:   cond_true = (op_r == OP_POP);
      C_V_ZERO:   cond_true = (v == '0);
      C_NOT_FULL: cond_true = !full;
      C_OUT_BUSY: cond_true = out_busy;
      default:    cond_true = 1'b1;
    endcase
    pc_next = cond_true ? uw.target : pc + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_WAIT;
      count     <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (out_valid && out_ready && uw.act != ACT_EMIT) begin
        out_valid <= 1'b0;
      end
      case (uw.act)
        ACT_ACCEPT: begin
          if (in_acc) begin
            op_r <= operation;
            v    <= value[31] ? '0 : value[30:0];
            st_r <= ST_OK;
          end
        end
        ACT_DIV: begin
          q <= q_calc;
        end
        ACT_PUSH: begin
          if (!full) begin
            v <= q_ext;
            if (!dup) begin
              count      <= count + CNT_W'(1);
              present[d] <= 1'b1;
            end
          end
        end
        ACT_OVF: begin
          st_r <= ST_OVERFLOW;
        end
        ACT_POP: begin
          if (count == '0) begin
            st_r <= ST_UNDERFLOW;
          end else begin
            count <= cnt_m1;
          end
        end
        ACT_UNMARK: begin
          if (st_r == ST_OK) begin
            present[dig_r] <= 1'b0;
          end
        end
        ACT_EMIT: begin
          if (!out_busy) begin
            out_valid    <= 1'b1;
            status       <= st_r;
            popped_digit <= dig_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (uw.act == ACT_PUSH && !full && !dup) begin
      store[count[IDX_W-1:0]] <= d;
    end
    if (uw.act == ACT_ACCEPT && in_acc) begin
      dig_r <= '0;
    end else if (uw.act == ACT_POP && count != '0) begin
      dig_r <= store[cnt_m1[IDX_W-1:0]];
    end
  end

endmodule

FILE: sv/uds_chk.sv
module uds_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [3:0] popped_digit
);
  import uds_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped_digit))
    else $error("Result beat changed while stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_OVERFLOW || status == ST_UNDERFLOW))
    else $error("Result beat carries an unknown status.");

  a_digit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> popped_digit == 4'd0)
    else $error("Failed operation returned a non-zero digit.");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> popped_digit <= 4'd9)
    else $error("Popped digit is not decimal.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken again in the cycle after a beat.");

endmodule

bind unique_digit_stack uds_chk u_uds_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .popped_digit (popped_digit)
);

FILE: verif/tb_unique_digit_stack.sv
module tb_unique_digit_stack;
  timeunit 1ns;
  timeprecision 1ps;

  import uds_pkg::*;

  typedef struct {
    logic [1:0] status;
    logic [3:0] digit;
  } stack_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              operation = OP_PUSH;
  logic signed [31:0] value = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [1:0]        status;
  logic [3:0]        popped_digit;

  logic [3:0]    held_digits [STACK_DEPTH];
  int            held_count;
  stack_result_t pending_results [$];
  bit            idle_on;
  int            fail_count;
  int            push_beats;
  int            pop_beats;
  int            underflow_seen;
  int            overflow_seen;
  int            deepest;
  int            results_seen;

  unique_digit_stack dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .popped_digit (popped_digit)
  );

  always #1 clk = ~clk;

  function automatic bit digit_held(input logic [3:0] d);
    for (int i = 0; i < held_count; i++) begin
      if (held_digits[i] == d) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Updates the predicted stack and returns the result the beat should give.
  function automatic stack_result_t predict_stack(input logic op, input logic [31:0] raw);
    stack_result_t r;
    logic [31:0]   rest;
    logic [3:0]    d;
    r.status = ST_OK;
    r.digit  = '0;
    if (op == OP_PUSH) begin
      push_beats++;
      if (!raw[31]) begin
        rest = raw;
        while (rest != 0) begin
          d = 4'(rest % 10);
          if (held_count >= STACK_DEPTH) begin
            r.status = ST_OVERFLOW;
            overflow_seen++;
            break;
          end
          if (!digit_held(d)) begin
            held_digits[held_count] = d;
            held_count++;
          end
          rest = rest / 10;
        end
      end
      if (held_count > deepest) deepest = held_count;
    end else begin
      pop_beats++;
      if (held_count == 0) begin
        r.status = ST_UNDERFLOW;
        underflow_seen++;
      end else begin
        held_count--;
        r.digit = held_digits[held_count];
      end
    end
    return r;
  endfunction

  task automatic send_beat(input logic op, input logic signed [31:0] val);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    value     = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_stack(op, val));
  endtask

  task automatic finish_beats();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready = (idle_on && $urandom_range(99) < 31) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    stack_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with nothing expected: status %0d, digit %0d",
               status, popped_digit);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          fail_count++;
        end
        if (popped_digit !== exp_r.digit) begin
          $error("popped_digit: expected %0d, got %0d", exp_r.digit, popped_digit);
          fail_count++;
        end
      end
    end
  end

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(9);
      2:       return $urandom_range(999);
      default: return $urandom_range(32'h7FFF_FFFF);
    endcase
  endfunction

  task automatic test_empty_pop();
    send_beat(OP_POP, 32'sd0);
    send_beat(OP_POP, -32'sd1);
  endtask

  task automatic test_push_extremes();
    send_beat(OP_PUSH, 32'sd0);
    send_beat(OP_PUSH, -32'sd1);
    send_beat(OP_PUSH, 32'sh8000_0000);
    send_beat(OP_PUSH, 32'sd1000000000);
    send_beat(OP_PUSH, 32'sd11);
    send_beat(OP_PUSH, 32'sd2147483647);
    send_beat(OP_PUSH, 32'sd1234567890);
    send_beat(OP_PUSH, 32'sd9876543);
    send_beat(OP_PUSH, 32'sd5);
  endtask

  task automatic test_drain();
    for (int i = 0; i < 11; i++) send_beat(OP_POP, -32'sd1);
    send_beat(OP_PUSH, 32'sd90);
    send_beat(OP_POP, 32'sh7FFF_FFFF);
  endtask

  task automatic test_random_mix(input int beats, input bit with_idle);
    idle_on = with_idle;
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(99) < 45) send_beat(OP_POP, $urandom);
      else send_beat(OP_PUSH, random_value());
    end
  endtask

  initial begin
    idle_on = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_empty_pop();
    test_push_extremes();
    idle_on = 1'b1;
    test_drain();
    test_random_mix(300, 1'b0);
    test_random_mix(1500, 1'b1);
    finish_beats();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d push and %0d pop beats, checked %0d results.",
             push_beats, pop_beats, results_seen);
    $display("Saw %0d underflows and %0d overflows; deepest stack %0d digits.",
             underflow_seen, overflow_seen, deepest);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run stopped by the time limit with %0d results outstanding.",
             pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
